>>> hdl/mvot_pkg.sv
// shared types and constants for the median-of-window over-voltage trip
// no dependencies; imported by mvot_cell, mvot_chain and the top level
package mvot_pkg;

	localparam int unsigned WINDOW_DEF      = 7;
	localparam int unsigned SAMPLE_BITS_DEF = 12;
	localparam int unsigned REG_BITS        = 12;
	localparam int unsigned SCALE_SHIFT     = 12;
	localparam int unsigned OUT_MAX         = 4095;
	localparam int unsigned SCALE_RESET     = 33 * 69;
	localparam int unsigned THRESH_RESET    = 1200;

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_SCALE_FACTOR   = 1'b0,
		REG_TRIP_THRESHOLD = 1'b1
	} reg_idx_t;

	// status handed from one sort cell to its right neighbor
	typedef struct packed {
		logic gt;   // incoming sample goes at or left of this cell
		logic vld;  // cell holds a sample of the current block
	} link_t;

endpackage

>>> hdl/mvot_cell.sv
// one insertion-sort cell: holds one sample, keeps the row in ascending order
// depends on mvot_pkg (link_t)
module mvot_cell #(
	parameter int unsigned DW = mvot_pkg::SAMPLE_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            ins,
	input  logic            clr,
	input  logic [DW-1:0]   x,
	input  mvot_pkg::link_t left_lk,
	input  logic [DW-1:0]   left_val,
	output mvot_pkg::link_t lk,
	output logic [DW-1:0]   val
);
	import mvot_pkg::*;

	logic          vld_q;
	logic [DW-1:0] val_q;
	logic          here_gt;

	// empty cells count as larger than any sample
	always_comb begin
		here_gt = !vld_q || (x < val_q);
		lk.gt   = here_gt;
		lk.vld  = vld_q;
		val     = val_q;
	end

	// occupancy: cleared at end of block, shifts in from left on insert
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (clr) begin
			vld_q <= 1'b0;
		end else if (ins && here_gt) begin
			vld_q <= left_lk.gt ? left_lk.vld : 1'b1;
		end
	end

	// value: take neighbor's word when shifting, else the new sample
	always_ff @(posedge clk) begin
		if (ins && here_gt) begin
			val_q <= left_lk.gt ? left_val : x;
		end
	end

endmodule

>>> hdl/mvot_chain.sv
// row of sort cells plus the block fill counter; presents the median cell
// depends on mvot_pkg and mvot_cell
module mvot_chain #(
	parameter int unsigned WINDOW = mvot_pkg::WINDOW_DEF,
	parameter int unsigned DW     = mvot_pkg::SAMPLE_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          ins,
	input  logic          clr,
	input  logic [DW-1:0] x,
	output logic          last,
	output logic          full,
	output logic [DW-1:0] median
);
	import mvot_pkg::*;

	localparam int unsigned CW = $clog2(WINDOW);

	link_t         lk [WINDOW];
	logic [DW-1:0] vals [WINDOW];
	logic [CW-1:0] cnt_q;

	// fill count within the current block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ins) begin
			cnt_q <= last ? '0 : cnt_q + 1'b1;
		end
	end

	assign last = (cnt_q == CW'(WINDOW - 1));

	// the cell row
	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		link_t         l_lk;
		logic [DW-1:0] l_val;
		if (i == 0) begin : g_head
			assign l_lk  = '{gt: 1'b0, vld: 1'b0};
			assign l_val = '0;
		end else begin : g_body
			assign l_lk  = lk[i-1];
			assign l_val = vals[i-1];
		end
		mvot_cell #(.DW(DW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ins      (ins),
			.clr      (clr),
			.x        (x),
			.left_lk  (l_lk),
			.left_val (l_val),
			.lk       (lk[i]),
			.val      (vals[i])
		);
	end

	assign median = vals[WINDOW/2];
	assign full   = lk[WINDOW-1].vld;

endmodule

>>> hdl/median_voltage_overvolt_trip.sv
// top level: median-of-window filter with scaled over-voltage trip
// depends on mvot_pkg and mvot_chain
//
// Usage:
//   Input words (sample) arrive on a valid/ready channel. Samples gather in
//   non-overlapping blocks of WINDOW; each sample is inserted into a row of
//   sort cells in the cycle it is accepted, so one sample per cycle is taken
//   while a block fills. The last sample of a block yields one output word:
//   the median times scale_factor, shifted right by 12 and saturated at
//   4095 (voltage_tenths), over_limit for this block, and the sticky
//   charge_cutoff flag.
//   After the last sample of a block is accepted, the median is scaled in the
//   multiply stage, then compared and saturated into the output register,
//   where out_valid rises. Input ready stays low while the median is
//   multiplied and compared, so the next block starts only once that
//   result is in the output register. If the receiver stalls, the output
//   register holds the word and samples keep being taken until the next
//   last-of-block sample, which waits. Reset clears the fill count, cell
//   occupancy, the output valid flag and the cutoff flag, and loads
//   scale_factor 2277 and trip_threshold 1200. Configuration writes are
//   registered; make them while no block result is in flight.
module median_voltage_overvolt_trip #(
	parameter int unsigned WINDOW      = mvot_pkg::WINDOW_DEF,
	parameter int unsigned SAMPLE_BITS = mvot_pkg::SAMPLE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wen,
	input  mvot_pkg::reg_idx_t               cfg_index,
	input  logic [mvot_pkg::REG_BITS-1:0]    cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [mvot_pkg::REG_BITS-1:0]    sample,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [mvot_pkg::REG_BITS-1:0]    voltage_tenths,
	output logic                             over_limit,
	output logic                             charge_cutoff
);
	import mvot_pkg::*;

	localparam int unsigned PW = SAMPLE_BITS + REG_BITS;
	localparam int unsigned VW = (SAMPLE_BITS > REG_BITS) ? SAMPLE_BITS : REG_BITS;

	logic [REG_BITS-1:0]    scale_q;
	logic [REG_BITS-1:0]    thr_q;
	logic                   acc_in;
	logic                   last;
	logic                   full;
	logic [SAMPLE_BITS-1:0] median;
	logic                   vld_s1;
	logic                   vld_s2;
	logic [PW-1:0]          prod_s2;
	logic [VW-1:0]          volts;
	logic                   over;
	logic                   out_valid_q;
	logic [REG_BITS-1:0]    volt_q;
	logic                   over_q;
	logic                   cutoff_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= REG_BITS'(SCALE_RESET);
			thr_q   <= REG_BITS'(THRESH_RESET);
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_SCALE_FACTOR:   scale_q <= cfg_data;
				REG_TRIP_THRESHOLD: thr_q   <= cfg_data;
				default:            ;
			endcase
		end
	end

	// input handshake: hold off while a block result is in flight
	assign in_ready = !vld_s1 && !vld_s2 && !(last && out_valid_q);
	assign acc_in   = in_valid && in_ready;

	mvot_chain #(.WINDOW(WINDOW), .DW(SAMPLE_BITS)) u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ins    (acc_in),
		.clr    (vld_s1),
		.x      (SAMPLE_BITS'(sample)),
		.last   (last),
		.full   (full),
		.median (median)
	);

	// stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= acc_in && last;
			vld_s2 <= vld_s1;
		end
	end

	// scale the median
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			prod_s2 <= PW'(median) * PW'(scale_q);
		end
	end

	// shift and compare; saturation is applied in the output register
	always_comb begin
		volts = VW'(prod_s2[PW-1:SCALE_SHIFT]);
		over  = volts > VW'(thr_q);
	end

	// output register and sticky cutoff
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cutoff_q    <= 1'b0;
		end else if (vld_s2) begin
			out_valid_q <= 1'b1;
			cutoff_q    <= cutoff_q | over;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			volt_q <= (volts > VW'(OUT_MAX)) ? REG_BITS'(OUT_MAX) : REG_BITS'(volts);
			over_q <= over;
		end
	end

	assign out_valid      = out_valid_q;
	assign voltage_tenths = volt_q;
	assign over_limit     = over_q;
	assign charge_cutoff  = cutoff_q;

	// checks
	a_cutoff_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		cutoff_q |=> cutoff_q)
		else $error("cutoff flag dropped without reset");

	a_over_sets_cutoff: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && over_q) |-> cutoff_q)
		else $error("trip word without cutoff flag");

	a_block_full: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> full)
		else $error("median taken from a partly filled row");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({vld_s1, vld_s2}))
		else $error("two block results in flight");

endmodule

>>> bench/tb_median_voltage_overvolt_trip.sv
// testbench for median_voltage_overvolt_trip: random and directed sample words, scoreboarded
// depends on mvot_pkg and the median_voltage_overvolt_trip rtl; self-checking, no files
module tb_median_voltage_overvolt_trip;
	timeunit 1ns;
	timeprecision 1ps;

	import mvot_pkg::*;

	localparam int unsigned WIN         = WINDOW_DEF;
	localparam int unsigned SBITS       = SAMPLE_BITS_DEF;
	localparam int unsigned STALL_LIMIT = 3000;
	localparam int unsigned HOLD_CYCLES = 150;
	localparam int unsigned PHASE_WORDS = 105;

	// one expected output word
	typedef struct packed {
		logic [REG_BITS-1:0] volts;
		logic                over;
		logic                cutoff;
	} trip_word_t;

	// tracks window fill, cutoff latch and registers; queues the words due
	class trip_tracker;
		logic [SBITS-1:0]    window [WIN];
		int unsigned         fill;
		logic                cutoff;
		logic [REG_BITS-1:0] scale;
		logic [REG_BITS-1:0] thresh;
		trip_word_t          words_due [$];
		int unsigned         errors;

		function new();
			fill   = 0;
			cutoff = 1'b0;
			scale  = REG_BITS'(SCALE_RESET);
			thresh = REG_BITS'(THRESH_RESET);
			errors = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [REG_BITS-1:0] value);
			case (idx)
				REG_SCALE_FACTOR: scale = value;
				REG_TRIP_THRESHOLD: thresh = value;
				default: ;
			endcase
		endfunction

		// accepted sample word: store it, and on the last of a block predict the output
		function void note_sample(logic [REG_BITS-1:0] raw);
			logic [SBITS-1:0]          sorted [WIN];
			logic [SBITS-1:0]          swap;
			logic [SBITS-1:0]          median;
			logic [SBITS+REG_BITS-1:0] volts;
			trip_word_t                w;
			if (fill >= WIN)
				fill = 0;
			window[fill] = SBITS'(raw);
			fill++;
			if (fill < WIN)
				return;
			fill = 0;
			// ascending order, upper middle element for an even window
			sorted = window;
			for (int pass = 0; pass < WIN - 1; pass++) begin
				for (int k = 0; k < WIN - 1 - pass; k++) begin
					if (sorted[k] > sorted[k+1]) begin
						swap        = sorted[k];
						sorted[k]   = sorted[k+1];
						sorted[k+1] = swap;
					end
				end
			end
			median = sorted[WIN/2];
			volts  = (median * scale) >> SCALE_SHIFT;
			// compare on the full value, saturate only the output
			w.over = (volts > thresh);
			if (w.over)
				cutoff = 1'b1;
			w.volts  = (volts > OUT_MAX) ? REG_BITS'(OUT_MAX) : REG_BITS'(volts);
			w.cutoff = cutoff;
			words_due.push_back(w);
		endfunction

		function void check_result(logic [REG_BITS-1:0] volts, logic over, logic cut);
			trip_word_t want;
			if (words_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected output word volts=%0d over=%b cutoff=%b",
						$realtime, volts, over, cut);
				return;
			end
			want = words_due.pop_front();
			if (want.volts !== volts || want.over !== over || want.cutoff !== cut) begin
				errors++;
				if (errors <= 10)
					$display("%0t: mismatch volts exp %0d got %0d, over exp %b got %b, cutoff exp %b got %b",
						$realtime, want.volts, volts, want.over, over, want.cutoff, cut);
			end
		endfunction

		function int pending();
			return words_due.size();
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_wen;
	reg_idx_t            cfg_index;
	logic [REG_BITS-1:0] cfg_data;
	logic                in_valid;
	logic                in_ready;
	logic [REG_BITS-1:0] sample;
	logic                out_valid;
	logic                out_ready;
	logic [REG_BITS-1:0] voltage_tenths;
	logic                over_limit;
	logic                charge_cutoff;

	trip_tracker tracker = new();
	bit          quiet;
	bit          hold_request;
	int unsigned stall_cycles;

	median_voltage_overvolt_trip u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wen        (cfg_wen),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.sample         (sample),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.voltage_tenths (voltage_tenths),
		.over_limit     (over_limit),
		.charge_cutoff  (charge_cutoff)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// monitor both channels and watch for a hang
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			tracker.note_sample(sample);
		if (arst_n && out_valid && out_ready)
			tracker.check_result(voltage_tenths, over_limit, charge_cutoff);
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_median_voltage_overvolt_trip: done, errors");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// receiver: random back-pressure plus one long hold-off on request
	initial begin : receiver
		int unsigned hold_left;
		hold_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= quiet || ($urandom_range(99) >= 11);
			end
		end
	end

	// offer one sample word, with an occasional gap before it
	task automatic push_sample(input logic [REG_BITS-1:0] value);
		if (!quiet && $urandom_range(99) < 11) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(2, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= value;
		do @(posedge clk); while (!in_ready);
	endtask

	// stop offering and wait for every expected word, then let the pipe settle
	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// write both registers on back-to-back edges
	task automatic set_regs(input logic [REG_BITS-1:0] scale, input logic [REG_BITS-1:0] thresh);
		cfg_wen   <= 1'b1;
		cfg_index <= REG_SCALE_FACTOR;
		cfg_data  <= scale;
		@(posedge clk);
		tracker.set_reg(REG_SCALE_FACTOR, scale);
		cfg_index <= REG_TRIP_THRESHOLD;
		cfg_data  <= thresh;
		@(posedge clk);
		tracker.set_reg(REG_TRIP_THRESHOLD, thresh);
		cfg_wen <= 1'b0;
	endtask

	// mix of uniform, extreme and near-threshold samples
	function automatic logic [REG_BITS-1:0] pick_sample(input int unsigned center);
		int unsigned lo;
		int unsigned hi;
		lo = (center > 40) ? center - 40 : 0;
		hi = (center + 40 > 4095) ? 4095 : center + 40;
		case ($urandom_range(9))
			0, 1, 2, 3: pick_sample = REG_BITS'($urandom_range(4095));
			4: pick_sample = $urandom_range(1) ? {REG_BITS{1'b1}} : {REG_BITS{1'b0}};
			default: pick_sample = REG_BITS'($urandom_range(hi, lo));
		endcase
	endfunction

	initial begin : stimulus
		logic [REG_BITS-1:0] directed [24];
		logic [REG_BITS-1:0] scale;
		logic [REG_BITS-1:0] thresh;
		int unsigned         center;
		// median 2160 sits just under the reset trip point, 2161 just over,
		// then a tie block shows the latch staying set, then a partial block
		directed = '{12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd2160,
			12'd4095, 12'd3000, 12'd2500, 12'd2161, 12'd100, 12'd50, 12'd0,
			12'd2160, 12'd2160, 12'd2160, 12'd2160, 12'd2160, 12'd2160, 12'd2160,
			12'd4095, 12'd4095, 12'd4095};
		arst_n       = 1'b0;
		cfg_wen      <= 1'b0;
		cfg_index    <= REG_SCALE_FACTOR;
		cfg_data     <= '0;
		in_valid     <= 1'b0;
		sample       <= '0;
		quiet        = 1'b0;
		hold_request = 1'b0;
		stall_cycles = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words under reset register values
		foreach (directed[i])
			push_sample(directed[i]);

		// random phases, each under its own register setting
		for (int p = 0; p < 6; p++) begin
			drain();
			case (p)
				0: begin scale = 12'hFFF; thresh = 12'hFFF; end
				1: begin scale = 12'h000; thresh = 12'h000; end
				3: begin scale = 12'hFFF; thresh = 12'h000; end
				5: begin scale = REG_BITS'(SCALE_RESET); thresh = REG_BITS'(THRESH_RESET); end
				default: begin
					scale  = REG_BITS'($urandom_range(4095));
					thresh = REG_BITS'($urandom_range(4095));
				end
			endcase
			set_regs(scale, thresh);
			// sample value whose median lands right at the trip point
			if (scale == 0)
				center = 2048;
			else
				center = ((int'(thresh) + 1) * 4096 + int'(scale) - 1) / int'(scale);
			if (center > 4095)
				center = 4095;
			quiet = (p == 2);
			for (int i = 0; i < PHASE_WORDS; i++) begin
				if (p == 3 && i == 20)
					hold_request = 1'b1;
				push_sample(pick_sample(center));
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (tracker.errors == 0)
			$display("tb_median_voltage_overvolt_trip: done, clean");
		else
			$display("tb_median_voltage_overvolt_trip: done, errors");
		$finish;
	end

endmodule
